// ----- design/cbse_pkg.sv -----
// Package: shared types, constants and table functions for the CRC32 byte stream engine.
`timescale 1ns / 1ps
package cbse_pkg;

    localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [31:0] MSB_MASK   = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [7:0]  FOLD_LO    = 8'h61;
    localparam logic [7:0]  FOLD_HI    = 8'h7A;
    localparam logic [7:0]  FOLD_DELTA = 8'h20;
    localparam int          TBL_BITS   = 8;

    typedef enum logic [1:0] {
        CFG_POLYNOMIAL = 2'd0,
        CFG_HASH_MODE  = 2'd1,
        CFG_CASE_FOLD  = 2'd2
    } t_cfg_index;

    typedef logic [TBL_BITS-1:0][31:0] t_basis;

    typedef struct packed {
        logic   hash_mode;
        logic   case_fold;
        t_basis basis;
    } t_cfg;

    // Table entry for one index: eight MSB-first shift-xor steps.
    function automatic logic [31:0] f_table_entry(input logic [7:0] idx,
                                                  input logic [31:0] poly);
        logic [31:0] v;
        v = {idx, 24'h0};
        for (int k = 0; k < TBL_BITS; k++) begin
            if ((v & MSB_MASK) != 32'h0) begin
                v = (v << 1) ^ poly;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

    // The table is linear in its index: keep the entries of the single-bit indexes.
    function automatic t_basis f_basis(input logic [31:0] poly);
        t_basis b;
        for (int k = 0; k < TBL_BITS; k++) begin
            b[k] = f_table_entry(8'(1 << k), poly);
        end
        return b;
    endfunction

endpackage

// ----- design/crc32_byte_stream_engine.sv -----
// Top level: input register, running register and result register of the CRC32 engine.
//
//  channel | direction | handshake                    | payload
//  in      | sink      | i_in_valid / o_in_stall      | data_byte, first_byte, last_byte, seed
//  out     | source    | o_out_valid / i_out_stall    | checksum
//  cfg     | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One byte per cycle while o_in_stall is low: a request enters the input register, is
//  folded into the running register and, on a last byte, lands in the result register.
//  A checksum is registered, with o_out_valid, as its last byte leaves the input register.
//  Reset is synchronous; it restores the default polynomial, CRC mode and a zero register.
//  A stalled result holds a following last byte in the input register, and the input
//  stalls until the result is taken; bytes that are not last never wait.
`timescale 1ns / 1ps
module crc32_byte_stream_engine
    import cbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_seed_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_checksum,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg        cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic        r_in_last;
    logic [31:0] r_in_seed;
    logic [31:0] r_run;
    logic        r_out_valid;
    logic [31:0] r_checksum;
    logic [31:0] n_run;
    logic [31:0] n_checksum;
    logic        advance;
    logic        take;

    cbse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    cbse_upd u_upd (
        .i_cfg        (cfg),
        .i_data_byte  (r_in_byte),
        .i_first_byte (r_in_first),
        .i_seed_value (r_in_seed),
        .i_run        (r_run),
        .o_next_run   (n_run),
        .o_checksum   (n_checksum)
    );

    // Hold a last byte while the previous result still waits.
    assign advance    = !(r_in_valid && r_in_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_run       <= 32'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_in_valid <= i_in_valid;
            end
            if (r_in_valid && advance) begin
                r_run <= n_run;
            end
            if (r_in_valid && advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
            r_in_seed  <= i_seed_value;
        end
        if (r_in_valid && advance && r_in_last) begin
            r_checksum <= n_checksum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;

`ifndef SYNTHESIS
    a_rise_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result appeared without a processed last byte");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled with no blocked last byte");

    a_run_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> $stable(r_run))
        else $error("running register changed with no byte in the stage");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (r_in_valid && r_in_last && $stable(r_run)))
        else $error("blocked last byte was dropped or applied");
`endif

endmodule

// ----- design/cbse_cfg.sv -----
// Configuration registers and the precomputed table basis.
`timescale 1ns / 1ps
module cbse_cfg
    import cbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    logic   r_hash_mode;
    logic   r_case_fold;
    t_basis r_basis;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode <= 1'b0;
            r_case_fold <= 1'b0;
            r_basis     <= f_basis(POLY_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLYNOMIAL: r_basis     <= f_basis(i_cfg_data);
                CFG_HASH_MODE:  r_hash_mode <= i_cfg_data[0];
                CFG_CASE_FOLD:  r_case_fold <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.hash_mode = r_hash_mode;
    assign o_cfg.case_fold = r_case_fold;
    assign o_cfg.basis     = r_basis;

endmodule

// ----- design/cbse_upd.sv -----
// Byte update: case folding, restart, table lookup and register step.
`timescale 1ns / 1ps
module cbse_upd
    import cbse_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_run,
    output logic [31:0] o_next_run,
    output logic [31:0] o_checksum
);

    logic [7:0]  byte_f;
    logic [31:0] start;
    logic [7:0]  idx;
    logic [31:0] entry;

    always_comb begin
        byte_f = i_data_byte;
        if (i_cfg.case_fold && (i_data_byte inside {[FOLD_LO:FOLD_HI]})) begin
            byte_f = i_data_byte - FOLD_DELTA;
        end

        if (i_first_byte) begin
            start = i_cfg.hash_mode ? 32'h0 : ~i_seed_value;
        end else begin
            start = i_run;
        end

        idx = i_cfg.hash_mode ? (start[7:0] ^ byte_f) : (start[31:24] ^ byte_f);

        entry = 32'h0;
        for (int k = 0; k < TBL_BITS; k++) begin
            if (idx[k]) begin
                entry = entry ^ i_cfg.basis[k];
            end
        end

        if (i_cfg.hash_mode) begin
            o_next_run = {8'h0, start[31:8]} ^ entry;
            o_checksum = o_next_run;
        end else begin
            o_next_run = {start[23:0], 8'h0} ^ entry;
            o_checksum = o_next_run ^ ALL_ONES;
        end
    end

endmodule
